// ----- hdl/usm_pkg.sv -----
// Shared types, codes and coil sequence tables for the stepper move sequencer.
package usm_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_MOVE    = 2'd1,
        FUNC_STOP    = 2'd2,
        FUNC_SET_POS = 2'd3
    } usm_func_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_DELAY = 2'd0;
    localparam logic [1:0] CFG_MAX_DELAY = 2'd1;
    localparam logic [1:0] CFG_MAX_POS   = 2'd2;
    localparam logic [1:0] CFG_STEP_MODE = 2'd3;

    // Register reset values
    localparam logic [15:0] MIN_DELAY_RESET = 16'd1000;
    localparam logic [15:0] MAX_DELAY_RESET = 16'd10000;
    localparam logic [15:0] MAX_POS_RESET   = 16'd0;

    // Speed scale: full speed is 100
    localparam logic [6:0] SPEED_FULL = 7'd100;
    localparam logic [6:0] ROUND_HALF = 7'd50;

    // Exact floor(x / 100) for x < 2**23: (x * ceil(2**30 / 100)) >> 30
    localparam int          SUM_W       = 23;
    localparam int          RECIP_W     = 24;
    localparam int          PROD_W      = SUM_W + RECIP_W;
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    // Coil ring in counter-clockwise order: A AB B BC C CD D DA
    localparam logic [3:0] SEQ_RING [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                            4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [3:0] FULL_START = 4'h3;
    localparam logic [3:0] HALF_START = 4'h1;

    // Result fields produced by the motion logic
    typedef struct packed {
        logic [3:0]  coils;
        logic [15:0] position;
        logic [15:0] steps_left;
        logic        done;
        logic        stepped;
    } usm_status_t;

    // Next coil pattern, one step in the given direction
    function automatic logic [3:0] usm_next_coils(input logic [3:0] pat,
                                                  input logic ccw,
                                                  input logic half);
        logic [2:0] at;
        logic       found;
        logic [2:0] move;
        logic [2:0] idx;
        logic [3:0] res;
        found = 1'b1;
        at    = 3'd0;
        case (pat)
            4'h1:    at = 3'd0;
            4'h3:    at = 3'd1;
            4'h2:    at = 3'd2;
            4'h6:    at = 3'd3;
            4'h4:    at = 3'd4;
            4'hC:    at = 3'd5;
            4'h8:    at = 3'd6;
            4'h9:    at = 3'd7;
            default: found = 1'b0;
        endcase
        // full step from a two-phase pattern skips the single-phase one
        move = (half || !at[0]) ? 3'd1 : 3'd2;
        idx  = ccw ? (at + move) : (at - move);
        if (!found)
            res = half ? HALF_START : FULL_START;
        else
            res = SEQ_RING[idx];
        return res;
    endfunction

endpackage

// ----- hdl/unipolar_stepper_move_sequencer.sv -----
// Top level of the unipolar stepper move sequencer: handshake pipeline and registers.
// Usage:
//   Input items arrive on s_tvalid/s_tready with the item kind in s_tuser
//   (tick, move, stop/query, set position) and its operands in s_tdata.
//   Every item yields exactly one result on m_tvalid/m_tready: coil pattern,
//   position, steps left, done, stepped and the step delay of the last move.
//   Registers (min/max delay, travel limit, step mode) are written through
//   cfg_valid/cfg_index/cfg_data, by the user only while no item is in flight;
//   the block does not enforce this. cfg_ready is always high.
// Timing:
//   Three register stages: input register, state update plus delay
//   products, reciprocal divide into the output register. An accepted item
//   passes the input, middle and output registers before m_tvalid rises;
//   one item per cycle is sustained while m_tready stays high.
// Reset:
//   rst_n clears the pipeline, turns all coils off, position and step count
//   to zero, done to one, and loads the register defaults.
// Stalls:
//   When m_tready is low the stages fill; s_tready drops only once all three
//   hold items, and results are held stable until taken.
module unipolar_stepper_move_sequencer #(
    parameter int POSITION_WIDTH   = 16,
    parameter int STEP_COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // speed[6:0], steps[22:7], direction[23], new_position[39:24]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // coils[3:0], position[19:4], steps_left[35:20],
                                   // done_res[36], stepped[37], step_delay_us[53:38], zero[55:54]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import usm_pkg::*;

    // configuration registers
    logic [15:0] min_delay_reg;
    logic [15:0] max_delay_reg;
    logic [15:0] max_pos_reg;
    logic        step_mode_reg;

    // pipeline registers
    logic        in_valid_reg;
    logic [39:0] in_data_reg;
    usm_func_t   in_func_reg;
    logic        mid_valid_reg;
    usm_status_t mid_status_reg;
    logic        mid_move_reg;
    logic        out_valid_reg;
    usm_status_t out_status_reg;
    logic [15:0] out_delay_reg;
    logic [15:0] delay_reg;
    logic [15:0] delay_next;

    logic        out_load;
    logic        mid_load;
    logic        in_load;
    usm_status_t status_next;
    logic [15:0] calc_delay;

    // stage advance: each stage moves on when the one after it frees up
    assign out_load = mid_valid_reg && (!out_valid_reg || m_tready);
    assign mid_load = in_valid_reg && (!mid_valid_reg || out_load);
    assign s_tready = !in_valid_reg || mid_load;
    assign in_load  = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg <= MIN_DELAY_RESET;
            max_delay_reg <= MAX_DELAY_RESET;
            max_pos_reg   <= MAX_POS_RESET;
            step_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_DELAY: min_delay_reg <= cfg_data;
                CFG_MAX_DELAY: max_delay_reg <= cfg_data;
                CFG_MAX_POS:   max_pos_reg   <= cfg_data;
                CFG_STEP_MODE: step_mode_reg <= cfg_data[0];
                default:       step_mode_reg <= step_mode_reg;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            delay_reg     <= '0;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (mid_load)
                in_valid_reg <= 1'b0;

            if (mid_load)
                mid_valid_reg <= 1'b1;
            else if (out_load)
                mid_valid_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                delay_reg     <= delay_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_tdata;
            in_func_reg <= usm_func_t'(s_tuser);
        end
        if (mid_load)
        begin
            mid_status_reg <= status_next;
            mid_move_reg   <= (in_func_reg == FUNC_MOVE);
        end
        if (out_load)
        begin
            out_status_reg <= mid_status_reg;
            out_delay_reg  <= delay_next;
        end
    end

    // delay held from the last move, replaced as a move reaches the output
    assign delay_next = mid_move_reg ? calc_delay : delay_reg;

    usm_motion #(
        .POSITION_WIDTH   (POSITION_WIDTH),
        .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
    ) u_motion (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_en      (mid_load),
        .func         (in_func_reg),
        .steps        (in_data_reg[22:7]),
        .direction    (in_data_reg[23]),
        .new_position (in_data_reg[39:24]),
        .max_position (max_pos_reg),
        .step_mode    (step_mode_reg),
        .status_next  (status_next)
    );

    usm_delay u_delay (
        .clk          (clk),
        .load_en      (mid_load),
        .speed        (in_data_reg[6:0]),
        .min_delay_us (min_delay_reg),
        .max_delay_us (max_delay_reg),
        .delay_us     (calc_delay)
    );

    // result packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_delay_reg, out_status_reg.stepped, out_status_reg.done,
                       out_status_reg.steps_left, out_status_reg.position,
                       out_status_reg.coils};

endmodule

// ----- hdl/usm_delay.sv -----
// Two-stage step delay calculation: weighted line value, then divide by 100.
module usm_delay (
    input  logic        clk,
    input  logic        load_en,
    input  logic [6:0]  speed,
    input  logic [15:0] min_delay_us,
    input  logic [15:0] max_delay_us,
    output logic [15:0] delay_us
);
    import usm_pkg::*;

    logic [6:0]        speed_sat;
    logic [6:0]        speed_inv;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod;

    // Stage 1: max*(100-s) + min*s + 50, at most 6553550
    always_comb
    begin
        speed_sat = (speed > SPEED_FULL) ? SPEED_FULL : speed;
        speed_inv = SPEED_FULL - speed_sat;
        sum_next  = SUM_W'(SUM_W'(max_delay_us) * SUM_W'(speed_inv))
                  + SUM_W'(SUM_W'(min_delay_us) * SUM_W'(speed_sat))
                  + SUM_W'(ROUND_HALF);
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
            sum_reg <= sum_next;
    end

    // Stage 2: reciprocal multiply, exact for the whole range of the sum
    assign prod     = PROD_W'(sum_reg) * PROD_W'(RECIP_100);
    assign delay_us = 16'(prod >> RECIP_SHIFT);

endmodule

// ----- hdl/usm_motion.sv -----
// Coil, position, step count and idle state, updated once per item.
module usm_motion #(
    parameter int POSITION_WIDTH   = 16,
    parameter int STEP_COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_en,
    input  usm_pkg::usm_func_t func,
    input  logic [15:0]        steps,
    input  logic               direction,
    input  logic [15:0]        new_position,
    input  logic [15:0]        max_position,
    input  logic               step_mode,
    output usm_pkg::usm_status_t status_next
);
    import usm_pkg::*;

    localparam int CMP_W = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16;

    logic [3:0]                  coils_reg, coils_next;
    logic [POSITION_WIDTH-1:0]   pos_reg, pos_next;
    logic [STEP_COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic                        dir_reg, dir_next;
    logic                        idle_reg, idle_next;
    logic                        stepped;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] max_ext;
    logic             allowed;
    logic [15:0]      clamped_pos;

    // Travel limit check for the stored direction
    always_comb
    begin
        pos_ext = CMP_W'(pos_reg);
        max_ext = CMP_W'(max_position);
        if (pos_ext > max_ext)
            allowed = 1'b0;
        else if (dir_reg)
            allowed = (pos_reg != '0);
        else
            allowed = (pos_ext < max_ext);
        clamped_pos = (new_position > max_position) ? max_position : new_position;
    end

    // Next state for one item
    always_comb
    begin
        coils_next = coils_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        dir_next   = dir_reg;
        idle_next  = idle_reg;
        stepped    = 1'b0;
        case (func)
            FUNC_TICK:
            begin
                if (!idle_reg)
                begin
                    if (!allowed || rem_reg == '0)
                        idle_next = 1'b1;
                    else
                    begin
                        coils_next = usm_next_coils(coils_reg, dir_reg, step_mode);
                        rem_next   = rem_reg - 1'b1;
                        pos_next   = dir_reg ? (pos_reg - 1'b1) : (pos_reg + 1'b1);
                        stepped    = 1'b1;
                    end
                end
            end
            FUNC_MOVE:
            begin
                rem_next  = STEP_COUNT_WIDTH'(steps);
                dir_next  = direction;
                idle_next = 1'b0;
            end
            FUNC_STOP:
                idle_next = 1'b1;
            FUNC_SET_POS:
                pos_next = POSITION_WIDTH'(clamped_pos);
            default:
                idle_next = idle_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coils_reg <= '0;
            pos_reg   <= '0;
            rem_reg   <= '0;
            dir_reg   <= 1'b0;
            idle_reg  <= 1'b1;
        end
        else if (item_en)
        begin
            coils_reg <= coils_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            dir_reg   <= dir_next;
            idle_reg  <= idle_next;
        end
    end

    // State after this item, as reported in the result
    always_comb
    begin
        status_next.coils      = coils_next;
        status_next.position   = 16'(pos_next);
        status_next.steps_left = 16'(rem_next);
        status_next.done       = idle_next;
        status_next.stepped    = stepped;
    end

endmodule

// ----- tb/sv/tb_unipolar_stepper_move_sequencer.sv -----
// Self-checking testbench for the unipolar stepper move sequencer.
module tb_unipolar_stepper_move_sequencer;
    import usm_pkg::*;

    localparam int SPEED_MAX    = 100;
    localparam int ROUND_UP     = SPEED_MAX / 2;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 82;
    localparam int MAX_PRINTED  = 50;

    // Coil patterns in counter-clockwise order: A AB B BC C CD D DA
    localparam logic [3:0] COIL_ORDER [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                              4'h4, 4'hC, 4'h8, 4'h9};

    // One input item before packing onto the bus
    typedef struct packed {
        usm_func_t   func;
        logic [6:0]  speed;
        logic [15:0] steps;
        logic        dir;
        logic [15:0] new_pos;
    } cmd_t;

    // Result item, laid out as on m_tdata (lowest field last)
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] delay;
        logic        stepped;
        logic        done;
        logic [15:0] steps_left;
        logic [15:0] position;
        logic [3:0]  coils;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // speed[6:0], steps[22:7], direction[23], new_position[39:24]
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // coils, position, steps_left, done_res, stepped, step_delay_us
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    unipolar_stepper_move_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Register mirror
    logic [15:0] lim_min   = MIN_DELAY_RESET;
    logic [15:0] lim_max   = MAX_DELAY_RESET;
    logic [15:0] lim_pos   = MAX_POS_RESET;
    logic        half_mode = 1'b0;

    // Motor state mirror
    logic [3:0]  coil_state  = 4'h0;
    logic [15:0] pos_state   = 16'd0;
    logic [15:0] left_state  = 16'd0;
    logic        ccw_state   = 1'b0;
    logic        idle_state  = 1'b1;
    logic [15:0] delay_state = 16'd0;

    cmd_t    pending_cmds [$];
    status_t expected_status [$];

    int unsigned items_queued    = 0;
    int unsigned items_driven    = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned moves_seen      = 0;
    int unsigned steps_taken     = 0;
    int unsigned half_steps      = 0;
    int unsigned mismatches      = 0;
    bit          no_gaps         = 1'b0;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Next coil pattern, one step in the given direction
    function automatic logic [3:0] next_coils(logic [3:0] pat, logic ccw, logic half);
        int at;
        int hop;
        at = -1;
        for (int i = 0; i < 8; i++)
            if (COIL_ORDER[i] == pat)
                at = i;
        if (at < 0)
            return half ? HALF_START : FULL_START;
        // full step from a two-phase pattern skips the single-phase one
        hop = (half || (at % 2 == 0)) ? 1 : 2;
        return ccw ? COIL_ORDER[(at + hop) % 8] : COIL_ORDER[(at + 8 - hop) % 8];
    endfunction

    // Apply one item to the motor mirror and return the status it yields
    function automatic status_t advance_motor(cmd_t c);
        status_t     r;
        int unsigned s;
        int unsigned mn;
        int unsigned mx;
        logic        ok;
        r.stepped = 1'b0;
        case (c.func)
            FUNC_TICK:
            begin
                if (!idle_state)
                begin
                    if (pos_state > lim_pos)
                        ok = 1'b0;
                    else if (ccw_state)
                        ok = (pos_state != 16'd0);
                    else
                        ok = (pos_state < lim_pos);
                    if (!ok || left_state == 16'd0)
                        idle_state = 1'b1;
                    else
                    begin
                        coil_state = next_coils(coil_state, ccw_state, half_mode);
                        left_state = left_state - 16'd1;
                        pos_state  = ccw_state ? pos_state - 16'd1 : pos_state + 16'd1;
                        r.stepped  = 1'b1;
                        steps_taken++;
                        if (half_mode)
                            half_steps++;
                    end
                end
            end
            FUNC_MOVE:
            begin
                s  = (c.speed > SPEED_MAX) ? SPEED_MAX : c.speed;
                mn = lim_min;
                mx = lim_max;
                left_state  = c.steps;
                ccw_state   = c.dir;
                delay_state = 16'((mx * (SPEED_MAX - s) + mn * s + ROUND_UP) / SPEED_MAX);
                idle_state  = 1'b0;
                moves_seen++;
            end
            FUNC_STOP:
                idle_state = 1'b1;
            default:
                pos_state = (c.new_pos > lim_pos) ? lim_pos : c.new_pos;
        endcase
        r.pad        = 2'b00;
        r.delay      = delay_state;
        r.done       = idle_state;
        r.steps_left = left_state;
        r.position   = pos_state;
        r.coils      = coil_state;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTED)
            $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_checked, name, got, want));
    endtask

    // Sample handshakes, mirror register writes, predict and check results
    always @(posedge clk)
    begin : monitor
        cmd_t    c;
        status_t got;
        status_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_DELAY: lim_min   = cfg_data;
                    CFG_MAX_DELAY: lim_max   = cfg_data;
                    CFG_MAX_POS:   lim_pos   = cfg_data;
                    CFG_STEP_MODE: half_mode = cfg_data[0];
                    default:       half_mode = half_mode;
                endcase
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                c.func    = usm_func_t'(s_tuser);
                c.speed   = s_tdata[6:0];
                c.steps   = s_tdata[22:7];
                c.dir     = s_tdata[23];
                c.new_pos = s_tdata[39:24];
                expected_status.push_back(advance_motor(c));
                items_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_status.size() == 0)
                    report_mismatch($sformatf("result %h with none expected", m_tdata));
                else
                begin
                    want = expected_status.pop_front();
                    check_field("coils",      got.coils,      want.coils);
                    check_field("position",   got.position,   want.position);
                    check_field("steps_left", got.steps_left, want.steps_left);
                    check_field("done",       got.done,       want.done);
                    check_field("stepped",    got.stepped,    want.stepped);
                    check_field("delay",      got.delay,      want.delay);
                    check_field("pad",        got.pad,        want.pad);
                    results_checked++;
                end
            end
        end
    end

    // Drive items and result backpressure at the falling edge
    always @(negedge clk)
    begin : driver
        cmd_t c;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            m_tready <= 1'b0;
        end
        else
        begin
            // the item on the bus is gone once every driven item was accepted
            if (!s_tvalid || items_accepted == items_driven)
            begin
                if (pending_cmds.size() != 0 && (no_gaps || $urandom_range(99) >= 25))
                begin
                    c = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= c.func;
                    s_tdata  <= {c.new_pos, c.dir, c.steps, c.speed};
                    items_driven++;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= no_gaps || ($urandom_range(99) >= 25);
        end
    end

    task automatic add_item(usm_func_t f, int unsigned sp, int unsigned st,
                            int unsigned d, int unsigned np);
        cmd_t c;
        c.func    = f;
        c.speed   = sp[6:0];
        c.steps   = st[15:0];
        c.dir     = d[0];
        c.new_pos = np[15:0];
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    // Ticks carry random operand bits, which the block must ignore
    task automatic add_ticks(int n);
        for (int k = 0; k < n; k++)
            add_item(FUNC_TICK, $urandom_range(127), $urandom_range(65535),
                     $urandom_range(1), $urandom_range(65535));
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] val);
        int unsigned start;
        start = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (cfg_writes == start);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every result has come back
    task automatic drain_pipeline();
        do
            @(negedge clk);
        while (items_accepted != items_queued || expected_status.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        int unsigned new_min;
        int unsigned new_max;
        int unsigned new_lim;
        int unsigned st;
        int          n;
        int          count;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset registers: travel limit zero blocks every step
        add_ticks(1);
        add_item(FUNC_SET_POS, 0, 0, 0, 16'hFFFF);
        add_item(FUNC_MOVE, 0, 3, 0, 0);
        add_ticks(1);
        add_item(FUNC_MOVE, 127, 16'hFFFF, 1, 0);
        add_ticks(1);
        drain_pipeline();

        // Full step near the top of the range, delay span 0..65535
        write_register(CFG_MAX_POS, 16'hFFFF);
        write_register(CFG_STEP_MODE, 16'd0);
        write_register(CFG_MIN_DELAY, 16'd0);
        write_register(CFG_MAX_DELAY, 16'hFFFF);
        add_item(FUNC_SET_POS, 0, 0, 0, 16'hFFFE);
        add_item(FUNC_MOVE, 100, 3, 0, 0);
        add_ticks(2);
        add_item(FUNC_MOVE, 101, 2, 1, 0);
        add_ticks(3);
        add_item(FUNC_MOVE, 50, 0, 0, 0);
        add_ticks(1);
        drain_pipeline();

        // Half step, inverted delay span, stop in mid-move
        write_register(CFG_STEP_MODE, 16'd1);
        write_register(CFG_MIN_DELAY, 16'hFFFF);
        write_register(CFG_MAX_DELAY, 16'd0);
        add_item(FUNC_SET_POS, 0, 0, 0, 100);
        add_item(FUNC_MOVE, 1, 3, 0, 0);
        add_ticks(3);
        add_item(FUNC_STOP, 0, 0, 0, 0);
        drain_pipeline();

        // Position above a lowered limit, then full step from a single-phase pattern
        write_register(CFG_STEP_MODE, 16'd0);
        write_register(CFG_MAX_POS, 16'd10);
        add_item(FUNC_MOVE, 30, 2, 1, 0);
        add_ticks(1);
        add_item(FUNC_SET_POS, 0, 0, 0, 5);
        add_item(FUNC_MOVE, 30, 2, 1, 0);
        add_ticks(2);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_pipeline();
            case (ph)
                0:
                begin
                    new_min = 16'hFFFF;
                    new_max = 16'hFFFF;
                    new_lim = 16'hFFFF;
                end
                1:
                begin
                    new_min = 0;
                    new_max = 0;
                    new_lim = $urandom_range(1, 40);
                end
                default:
                begin
                    new_min = ($urandom_range(3) == 0) ? 16'hFFFF * $urandom_range(1)
                                                       : $urandom_range(65535);
                    new_max = ($urandom_range(3) == 0) ? 16'hFFFF * $urandom_range(1)
                                                       : $urandom_range(65535);
                    case ($urandom_range(3))
                        0:       new_lim = 0;
                        1:       new_lim = 16'hFFFF;
                        default: new_lim = $urandom_range(1, 40);
                    endcase
                end
            endcase
            write_register(CFG_MIN_DELAY, new_min[15:0]);
            write_register(CFG_MAX_DELAY, new_max[15:0]);
            write_register(CFG_MAX_POS, new_lim[15:0]);
            write_register(CFG_STEP_MODE, (ph < 2) ? 16'(1 - ph) : 16'($urandom_range(1)));
            no_gaps = (ph == 2);

            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 70)
                begin
                    // well-formed move: optional placement, command, then ticks with an occasional stop
                    if ($urandom_range(2) == 0)
                    begin
                        case ($urandom_range(3))
                            0:       st = $urandom_range(5);
                            1:       st = (new_lim - $urandom_range(5)) & 16'hFFFF;
                            2:       st = $urandom_range(65535);
                            default: st = $urandom_range(new_lim);
                        endcase
                        add_item(FUNC_SET_POS, $urandom_range(127), $urandom_range(65535),
                                 $urandom_range(1), st);
                        count++;
                    end
                    st = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(12);
                    add_item(FUNC_MOVE, $urandom_range(127), st, $urandom_range(1),
                             $urandom_range(65535));
                    n = ((st > 16) ? 16 : st) + $urandom_range(2);
                    for (int k = 0; k < n; k++)
                    begin
                        if ($urandom_range(19) == 0)
                            add_item(FUNC_STOP, $urandom_range(127), $urandom_range(65535),
                                     $urandom_range(1), $urandom_range(65535));
                        else
                            add_ticks(1);
                    end
                    count += n + 1;
                end
                else
                begin
                    add_item(usm_func_t'($urandom_range(3)), $urandom_range(127),
                             $urandom_range(65535), $urandom_range(1),
                             $urandom_range(65535));
                    count++;
                end
            end
        end

        drain_pipeline();
        no_gaps = 1'b0;
        repeat (10) @(negedge clk);
        if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_status.size()));

        $display("checked %0d results from %0d items: %0d moves, %0d steps (%0d half steps)",
                 results_checked, items_accepted, moves_seen, steps_taken, half_steps);
        $display("%0d register writes over %0d random settings plus directed cases",
                 cfg_writes, PHASES);
        if (mismatches == 0)
            $display("tb_unipolar_stepper_move_sequencer: done, clean");
        else
            $display("tb_unipolar_stepper_move_sequencer: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_unipolar_stepper_move_sequencer: done, errors");
        $finish;
    end

endmodule
